### rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types and constants of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

   // depth of the queue between classifier and decode engine
   localparam int unsigned Q_DEPTH = 2;

   // ascii codes that carry meaning
   localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
   localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CH_DIG_0 = 8'h30;
   localparam logic [7:0] CH_DIG_9 = 8'h39;

   // sextet bases of the alphabet ranges
   localparam logic [5:0] SX_LOWER = 6'd26;
   localparam logic [5:0] SX_DIGIT = 6'd52;
   localparam logic [5:0] SX_PLUS  = 6'd62;
   localparam logic [5:0] SX_SLASH = 6'd63;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_PAD,
      KIND_BAD
   } char_kind_type;

   // classified character as it travels through the queue
   typedef struct packed {
      char_kind_type kind;
      logic [5:0]    sextet;
      logic          last;
   } char_item_type;

endpackage

### rtl/core/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// request side: classifies each character and pushes it into the queue
// ----------------------------------------------------------------------------
module b64d_front
   import b64d_pkg::*;
(
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   input  logic          q_full,
   output logic          push,
   output char_item_type item
);

   always_comb begin
      item.kind   = KIND_BAD;
      item.sextet = '0;
      item.last   = req_tlast;
      if (req_tdata >= CH_UP_A && req_tdata <= CH_UP_Z) begin
         item.kind   = KIND_DATA;
         item.sextet = 6'(req_tdata - CH_UP_A);
      end else if (req_tdata >= CH_LO_A && req_tdata <= CH_LO_Z) begin
         item.kind   = KIND_DATA;
         item.sextet = 6'(req_tdata - CH_LO_A) + SX_LOWER;
      end else if (req_tdata >= CH_DIG_0 && req_tdata <= CH_DIG_9) begin
         item.kind   = KIND_DATA;
         item.sextet = 6'(req_tdata - CH_DIG_0) + SX_DIGIT;
      end else if (req_tdata == CH_PLUS) begin
         item.kind   = KIND_DATA;
         item.sextet = SX_PLUS;
      end else if (req_tdata == CH_SLASH) begin
         item.kind   = KIND_DATA;
         item.sextet = SX_SLASH;
      end else if (req_tdata == CH_PAD) begin
         item.kind   = KIND_PAD;
      end
   end

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

endmodule

### rtl/core/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// small flop queue between classifier and decode engine
// ----------------------------------------------------------------------------
module b64d_queue
   import b64d_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  char_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          q_valid,
   output char_item_type head_item
);

   localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int unsigned CW = $clog2(Q_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(Q_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(Q_DEPTH);

   char_item_type mem_ff [Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign q_valid   = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// decode engine: bit accumulator, pad and error tracking, byte count and
// the response register
// ----------------------------------------------------------------------------
module b64d_back
   import b64d_pkg::*;
#(
   parameter int unsigned MAX_OUT_BYTES = 255
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  char_item_type head_item,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata,
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   localparam logic [7:0] CAP = (MAX_OUT_BYTES > 255) ? 8'd255 : 8'(MAX_OUT_BYTES);

   // only the low six bits of the accumulator survive between characters
   logic [5:0]  acc_ff, acc_in;
   logic [2:0]  pend_ff, pend_in;
   logic        pad_ff, pad_in;
   logic        err_ff, err_in;
   logic [7:0]  count_ff, count_in;

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  total_ff, total_in;
   logic        vld_ff, vld_in;
   logic        done_ff, done_in;
   logic        bad_ff, bad_in;

   logic [11:0] acc_wide;
   logic [3:0]  sum;
   logic [7:0]  new_byte;
   logic        has_res;

   assign pop      = q_valid && (!rsp_tvalid_ff || rsp_tready);
   assign acc_wide = {acc_ff, head_item.sextet};
   assign sum      = {1'b0, pend_ff} + 4'd6;

   always_comb begin
      case (sum)
         4'd8:    new_byte = acc_wide[7:0];
         4'd10:   new_byte = acc_wide[9:2];
         4'd12:   new_byte = acc_wide[11:4];
         default: new_byte = '0;
      endcase
   end

   always_comb begin
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      pad_in   = pad_ff;
      err_in   = err_ff;
      count_in = count_ff;
      has_res  = 1'b0;
      vld_in   = 1'b0;
      byte_in  = '0;
      done_in  = 1'b0;
      bad_in   = 1'b0;
      total_in = count_ff;
      if (err_ff) begin
         // skip to end of text, silently
      end else if (pad_ff || head_item.kind == KIND_PAD) begin
         pad_in = 1'b1;
         if (head_item.last) begin
            has_res = 1'b1;
            done_in = 1'b1;
         end
      end else if (head_item.kind == KIND_DATA) begin
         acc_in = acc_wide[5:0];
         if (sum >= 4'd8) begin
            pend_in  = 3'(sum - 4'd8);
            count_in = (count_ff < CAP) ? count_ff + 1'b1 : count_ff;
            has_res  = 1'b1;
            vld_in   = 1'b1;
            byte_in  = new_byte;
            done_in  = head_item.last;
            total_in = count_in;
         end else begin
            pend_in = 3'(sum);
            if (head_item.last) begin
               has_res = 1'b1;
               done_in = 1'b1;
            end
         end
      end else begin
         // invalid character
         has_res = 1'b1;
         done_in = 1'b1;
         bad_in  = 1'b1;
         err_in  = 1'b1;
      end
      if (head_item.last) begin
         acc_in   = '0;
         pend_in  = '0;
         pad_in   = 1'b0;
         err_in   = 1'b0;
         count_in = '0;
      end
   end

   always_comb begin
      if (pop) begin
         rsp_tvalid_in = has_res;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         pend_ff       <= '0;
         pad_ff        <= 1'b0;
         err_ff        <= 1'b0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (pop) begin
            acc_ff   <= acc_in;
            pend_ff  <= pend_in;
            pad_ff   <= pad_in;
            err_ff   <= err_in;
            count_ff <= count_in;
         end
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && has_res) begin
         vld_ff   <= vld_in;
         byte_ff  <= byte_in;
         done_ff  <= done_in;
         bad_ff   <= bad_in;
         total_ff <= total_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {total_ff, byte_ff};
   assign rsp_tuser  = {bad_ff, vld_ff};
   assign rsp_tlast  = done_ff;

endmodule

### rtl/core/base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// streaming base64 decoder, one character per request
// ----------------------------------------------------------------------------
// takes one character per cycle while responses are taken, with a flag on the
// last character of a text; a request waits in the queue and its response in
// the response register. the rate is set by the decode engine, which folds one
// character a cycle into its accumulator while its response register is free
// or taken; a two-entry queue decouples the classifier from the engine so that
// a stalled response side costs no throughput until the queue fills. a response
// carries a decoded byte whenever eight bits have gathered, a done flag on the
// last character of a text, or an error on a character outside the alphabet;
// after an error, characters are dropped up to and including the last one.
// after '=' every character is ignored and the last one gives the done result.
// the byte count saturates at min(MAX_OUT_BYTES, 255).
// ----------------------------------------------------------------------------
module base64_stream_decoder_core
   import b64d_pkg::*;
#(
   parameter int unsigned MAX_OUT_BYTES = 255
)
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_char
   input  logic        req_tlast,   // is_final_char
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] decoded_byte, [15:8] byte_total
   output logic [1:0]  rsp_tuser,   // [0] byte_valid, [1] bad_char
   output logic        rsp_tlast    // done_res
);

   localparam logic [7:0] CAP = (MAX_OUT_BYTES > 255) ? 8'd255 : 8'(MAX_OUT_BYTES);

   // classifier to queue
   logic          push;
   char_item_type push_item;
   logic          q_full;

   // queue to decode engine
   logic          q_valid;
   logic          pop;
   char_item_type head_item;

   // front: map the character to a sextet or a pad / bad mark
   b64d_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .item       (push_item)
   );

   // queue: lets request and response sides stall apart
   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .head_item (head_item)
   );

   // back: accumulator, counters and the response register
   b64d_back #(
      .MAX_OUT_BYTES (MAX_OUT_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // the count never passes its saturation limit
   a_total_cap : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:8] <= CAP)
      else $error("byte_total above saturation limit");

   // an error response ends the text and carries no byte
   a_bad_done : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && !rsp_tuser[0])
      else $error("error response without done or with a byte");

   // a decoded byte is always counted
   a_byte_counted : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[15:8] != 8'd0)
      else $error("byte emitted with zero count");

   // a response without a byte carries a zero byte field
   a_byte_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[7:0] == 8'd0)
      else $error("stale byte on a response without a byte");
`endif

endmodule

### test/base64_stream_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core_tb
// self-checking bench for the streaming base64 decoder
// ----------------------------------------------------------------------------
// characters go in one request at a time; a decode predictor follows every
// accepted request and queues the response it should cause, and every response
// taken from the block is checked field by field against the oldest entry.
// directed texts cover the alphabet ranges, padding, bad characters and the
// count ceiling, then random texts run with random gaps on both sides, a long
// response hold-off that backs up the input, and gap-free stretches
// ----------------------------------------------------------------------------
module base64_stream_decoder_core_tb
   import b64d_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_OUT_BYTES  = 255;
   localparam int unsigned COUNT_CAP      = (MAX_OUT_BYTES > 255) ? 255 : MAX_OUT_BYTES;
   localparam int          TARGET_CHARS   = 1250;
   localparam int          DRAIN_CYCLES   = 8;     // extra wait after the last expected response
   localparam int          HOLD_CYCLES    = 300;   // long response hold-off
   localparam int          WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
   localparam int          MAX_PRINTED    = 40;

   typedef logic [7:0] char_q_type[$];

   // one decoder response as the predictor sees it
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       done;
      logic       bad;
      logic [7:0] total;
   } decode_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // text_char
   logic        req_tlast  = 1'b0;   // is_final_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] decoded_byte, [15:8] byte_total
   logic [1:0]  rsp_tuser;           // [0] byte_valid, [1] bad_char
   logic        rsp_tlast;           // done_res

   // predictor state, cleared at the end of every text
   logic [11:0] acc_bits;
   logic [3:0]  acc_count;
   logic        pad_flag;
   logic        err_flag;
   logic [7:0]  byte_count;

   decode_result_type decoded_results_q[$];

   int error_count   = 0;
   int chars_sent    = 0;
   int idle_cycles   = 0;
   bit src_gaps_on   = 1'b1;
   bit sink_gaps_on  = 1'b1;
   int rsp_gap_left  = 0;
   int rsp_hold_left = 0;

   base64_stream_decoder_core #(
      .MAX_OUT_BYTES(MAX_OUT_BYTES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // decode predictor
   // ------------------------------------------------------------------------

   // six-bit value of an alphabet character, -1 for anything else
   function automatic int sextet_value(logic [7:0] ch);
      if (ch >= CH_UP_A && ch <= CH_UP_Z) return int'(ch - CH_UP_A);
      if (ch >= CH_LO_A && ch <= CH_LO_Z) return int'(ch - CH_LO_A) + int'(SX_LOWER);
      if (ch >= CH_DIG_0 && ch <= CH_DIG_9) return int'(ch - CH_DIG_0) + int'(SX_DIGIT);
      if (ch == CH_PLUS) return int'(SX_PLUS);
      if (ch == CH_SLASH) return int'(SX_SLASH);
      return -1;
   endfunction

   function automatic logic [7:0] alphabet_char(int unsigned sx);
      if (sx < SX_LOWER) return CH_UP_A + 8'(sx);
      if (sx < SX_DIGIT) return CH_LO_A + 8'(sx - SX_LOWER);
      if (sx < SX_PLUS) return CH_DIG_0 + 8'(sx - SX_DIGIT);
      if (sx == SX_PLUS) return CH_PLUS;
      return CH_SLASH;
   endfunction

   function automatic logic [7:0] random_bad_char();
      logic [7:0] ch;
      do
         ch = 8'($urandom_range(0, 255));
      while (sextet_value(ch) >= 0 || ch == CH_PAD);
      return ch;
   endfunction

   task automatic clear_decode_state();
      acc_bits   = '0;
      acc_count  = '0;
      pad_flag   = 1'b0;
      err_flag   = 1'b0;
      byte_count = '0;
   endtask

   // folds one accepted character into the predictor and queues its response
   task automatic decode_char(input logic [7:0] ch, input logic last);
      decode_result_type res;
      int                sx;
      res = '0;
      sx  = sextet_value(ch);
      if (err_flag) begin
         // skipping to the end of a broken text, no response at all
         if (last) clear_decode_state();
      end else if (pad_flag || ch == CH_PAD) begin
         pad_flag = 1'b1;
         if (last) begin
            res.done  = 1'b1;
            res.total = byte_count;
            decoded_results_q.push_back(res);
            clear_decode_state();
         end
      end else if (sx < 0) begin
         res.done  = 1'b1;
         res.bad   = 1'b1;
         res.total = byte_count;
         decoded_results_q.push_back(res);
         if (last) clear_decode_state();
         else err_flag = 1'b1;
      end else begin
         acc_bits  = {acc_bits[5:0], 6'(sx)};
         acc_count = {1'b0, acc_count[2:0]} + 4'd6;
         if (acc_count >= 4'd8) begin
            res.byte_valid = 1'b1;
            res.data_byte  = 8'(acc_bits >> (acc_count - 4'd8));
            acc_count      = acc_count - 4'd8;
            if (byte_count < COUNT_CAP) byte_count = byte_count + 8'd1;
            res.done  = last;
            res.total = byte_count;
            decoded_results_q.push_back(res);
            if (last) clear_decode_state();
         end else if (last) begin
            // leftover partial bits are dropped
            res.done  = 1'b1;
            res.total = byte_count;
            decoded_results_q.push_back(res);
            clear_decode_state();
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_PRINTED)
         $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // handshake monitor, response checker and watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      decode_result_type want;
      if (reset) begin
         clear_decode_state();
         idle_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) decode_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_results_q.size() == 0) begin
               report_mismatch("response with nothing expected, data", int'(rsp_tdata), 0);
            end else begin
               want = decoded_results_q.pop_front();
               if (rsp_tuser[0] !== want.byte_valid)
                  report_mismatch("byte_valid", int'(rsp_tuser[0]), int'(want.byte_valid));
               if (rsp_tdata[7:0] !== want.data_byte)
                  report_mismatch("decoded_byte", int'(rsp_tdata[7:0]), int'(want.data_byte));
               if (rsp_tlast !== want.done)
                  report_mismatch("done_res", int'(rsp_tlast), int'(want.done));
               if (rsp_tuser[1] !== want.bad)
                  report_mismatch("bad_char", int'(rsp_tuser[1]), int'(want.bad));
               if (rsp_tdata[15:8] !== want.total)
                  report_mismatch("byte_total", int'(rsp_tdata[15:8]), int'(want.total));
            end
            // gap before the next response is taken
            rsp_gap_left = sink_gaps_on ? $urandom_range(0, 7) : 0;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   // response side: long hold-off first, then the per-response gap
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offers one character after a random gap and waits for the handshake
   task automatic send_char(input logic [7:0] ch, input logic last);
      int gap;
      gap = src_gaps_on ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      chars_sent++;
   endtask

   task automatic send_text(input char_q_type text);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic send_string(input string s);
      char_q_type text;
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      send_text(text);
   endtask

   // stops offering and waits for every expected response plus the latency
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (decoded_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed texts, some broken by a bad character, some pure noise
   task automatic send_random_text(input int max_len);
      char_q_type text;
      int         kind;
      int         len;
      int         pads;
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, max_len);
      if (kind < 70) begin
         for (int i = 0; i < len; i++) text.push_back(alphabet_char($urandom_range(0, 63)));
         pads = (len % 4 == 2) ? 2 : (len % 4 == 3) ? 1 : 0;
         if ($urandom_range(0, 3) == 0) pads = $urandom_range(0, 3);
         repeat (pads) text.push_back(CH_PAD);
         // ignored junk after the padding now and then
         if (pads != 0 && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
         for (int i = 0; i < len; i++) text.push_back(alphabet_char($urandom_range(0, 63)));
         text[$urandom_range(0, len - 1)] = random_bad_char();
      end else begin
         for (int i = 0; i < len; i++) text.push_back(8'($urandom_range(0, 255)));
      end
      send_text(text);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_directed();
      src_gaps_on  = 1'b1;
      sink_gaps_on = 1'b1;
      send_string("TWFu");            // three bytes, the last one with done
      send_string("TQ==");            // one byte then padding to the end
      send_string("AB*CD");           // bad character mid-text, rest skipped
      send_char(8'hFF, 1'b1);         // non-ascii as the only, last character
      send_char(8'h00, 1'b0);         // bad character not last
      send_char(8'h80, 1'b1);         // ends the skipped text without response
      send_string("+/9za0Z");         // both ends of the digit and lower-case ranges, 'Z', '+' and '/'
      send_string("A");               // partial bits only, dropped
      send_string("=");               // lone pad as last character
      send_string("Q=*x");            // bad character after pad is ignored
      wait_drained();
   endtask

   // one long text so the byte count reaches its ceiling
   task automatic test_count_saturation();
      char_q_type text;
      src_gaps_on  = 1'b0;
      sink_gaps_on = 1'b0;
      for (int i = 0; i < 4 * ((COUNT_CAP + 8) / 3); i++)
         text.push_back(alphabet_char($urandom_range(0, 63)));
      send_text(text);
      wait_drained();
   endtask

   // responses held off for a long stretch while requests keep coming
   task automatic test_backpressure();
      char_q_type text;
      src_gaps_on   = 1'b0;
      sink_gaps_on  = 1'b1;
      rsp_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 64; i++) text.push_back(alphabet_char($urandom_range(0, 63)));
      send_text(text);
      wait_drained();
   endtask

   task automatic test_no_idle();
      int stop_at;
      src_gaps_on  = 1'b0;
      sink_gaps_on = 1'b0;
      stop_at      = chars_sent + 150;
      while (chars_sent < stop_at) send_random_text(24);
      wait_drained();
   endtask

   task automatic test_random();
      while (chars_sent < TARGET_CHARS) begin
         // idling switched per text, so some texts run with no gaps at all
         src_gaps_on  = ($urandom_range(0, 3) != 0);
         sink_gaps_on = ($urandom_range(0, 3) != 0);
         send_random_text(40);
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_count_saturation();
      test_backpressure();
      test_no_idle();
      test_random();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### files.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder_core.sv
test/base64_stream_decoder_core_tb.sv
